// ----- hw/rtl/bloom_filter_double_hash_macros.svh -----
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shared property shorthands for the bloom filter checker.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFDH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BFDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bfdh_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Widths, reset values, codes and shared types of the bloom filter block.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   localparam int HASH_W       = 64;
   localparam int NUM_BITS_W   = 17;
   localparam int HASH_COUNT_W = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;

   localparam int MAX_BITS_DEFAULT   = 65536;
   localparam int MAX_HASHES_DEFAULT = 16;

   localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RESET   = 17'd65536;
   localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RESET = 5'd7;

   // substitute for an all-zero step hash
   localparam logic [HASH_W-1:0] ZERO_STEP_SUBST = 64'h0000_0000_27d4_eb2d;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_COUNT = 2'd1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_PROBE,
      ST_CHECK,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [NUM_BITS_W-1:0] remainder;
   } mod_result_type;

endpackage

// ----- hw/rtl/bfdh_ram.sv -----
// ----------------------------------------------------------------------------
// Bloom filter generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfdh_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/bfdh_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Bloom filter modulo unit
// Restoring remainder of a 64-bit dividend by a 17-bit modulus, one bit a cycle.
// ----------------------------------------------------------------------------
module bfdh_mod_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bfdh_pkg::HASH_W-1:0]        dividend,
   input  logic [bfdh_pkg::NUM_BITS_W-1:0]    modulus,
   output bfdh_pkg::mod_result_type           result
);

   localparam int NB     = bfdh_pkg::NUM_BITS_W;
   localparam int DW     = bfdh_pkg::HASH_W;
   localparam int STEP_W = $clog2(DW);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

   logic [DW-1:0]     dividend_ff, dividend_in;
   logic [NB-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NB:0]       trial;
   logic [NB:0]       modulus_ext;

   assign trial       = {rem_ff, dividend_ff[DW-1]};
   assign modulus_ext = {1'b0, modulus};

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         dividend_in = dividend;
         rem_in      = '0;
         step_in     = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[DW-2:0], 1'b0};
         // partial remainder stays below twice the modulus: one subtract
         if (trial >= modulus_ext) begin
            rem_in = NB'(trial - modulus_ext);
         end else begin
            rem_in = trial[NB-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

// ----- hw/rtl/bloom_filter_double_hash.sv -----
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Insert and query of 64-bit key hash pairs against an on-chip bit store.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | operation, key_hash, step_hash
//   rsp     | out       | rsp_valid / rsp_ready  | possibly_present
//   csr     | in        | csr_wr_en              | csr_index, csr_wr_data
//
// Each probe runs the bit-serial modulo unit over the running hash, then sets
// the bit for an insert or reads and tests it for a query; an item makes k
// probes, k being the effective hash count. A query ends at its first clear bit.
// After reset the bit store is swept clear with req_ready low.
// A waiting result in the rsp register does not block the next accept; only
// the final write-back of the next result waits for it.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
   parameter int MAX_BITS   = bfdh_pkg::MAX_BITS_DEFAULT,
   parameter int MAX_HASHES = bfdh_pkg::MAX_HASHES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [bfdh_pkg::HASH_W-1:0]         req_key_hash,
   input  logic [bfdh_pkg::HASH_W-1:0]         req_step_hash,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_possibly_present,
   input  logic                                csr_wr_en,
   input  logic [bfdh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int NB     = bfdh_pkg::NUM_BITS_W;
   localparam int HC     = bfdh_pkg::HASH_COUNT_W;
   localparam int HW     = bfdh_pkg::HASH_W;
   localparam int ADDR_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BITS - 1);

   bfdh_pkg::state_type state_ff, state_in;

   logic [NB-1:0]     num_bits_ff, num_bits_in;
   logic [HC-1:0]     hash_count_ff, hash_count_in;
   logic              op_ff, op_in;
   logic [HW-1:0]     acc_ff, acc_in;
   logic [HW-1:0]     step_ff, step_in;
   logic [NB-1:0]     modulus_ff, modulus_in;
   logic [HC-1:0]     probes_ff, probes_in;
   logic [HC-1:0]     probe_idx_ff, probe_idx_in;
   logic              present_ff, present_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_present_ff, rsp_present_in;

   logic [NB-1:0]        eff_modulus;
   logic [HC-1:0]        eff_probes;
   logic [HC-1:0]        probe_idx_next;
   logic                 last_probe;
   logic                 rsp_free;
   logic                 mod_start;
   bfdh_pkg::mod_result_type mod_result;
   logic [ADDR_W+NB-1:0] rem_wide;
   logic [ADDR_W-1:0]    probe_addr;

   logic              ram_en;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [0:0]        ram_wdata;
   logic [0:0]        ram_rdata;

   // saturate the configuration to what the store and probe counter hold; a zero size counts as one
   always_comb begin
      if (num_bits_ff == '0) begin
         eff_modulus = NB'(1);
      end else if (32'(num_bits_ff) > 32'(MAX_BITS)) begin
         eff_modulus = NB'(MAX_BITS);
      end else begin
         eff_modulus = num_bits_ff;
      end
      if (32'(hash_count_ff) > 32'(MAX_HASHES)) begin
         eff_probes = HC'(MAX_HASHES);
      end else begin
         eff_probes = hash_count_ff;
      end
   end

   assign probe_idx_next = probe_idx_ff + HC'(1);
   assign last_probe     = (probe_idx_next == probes_ff);
   assign rsp_free       = !rsp_valid_ff || rsp_ready;
   assign rem_wide       = {{ADDR_W{1'b0}}, mod_result.remainder};
   assign probe_addr     = rem_wide[ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (eff_probes == '0) ? bfdh_pkg::ST_RESPOND : bfdh_pkg::ST_START;
            end
         end
         bfdh_pkg::ST_START: begin
            state_in = bfdh_pkg::ST_DIVIDE;
         end
         bfdh_pkg::ST_DIVIDE: begin
            if (mod_result.done) begin
               state_in = bfdh_pkg::ST_PROBE;
            end
         end
         bfdh_pkg::ST_PROBE: begin
            if (op_ff == bfdh_pkg::OP_QUERY) begin
               state_in = bfdh_pkg::ST_CHECK;
            end else if (last_probe) begin
               state_in = bfdh_pkg::ST_RESPOND;
            end else begin
               state_in = bfdh_pkg::ST_START;
            end
         end
         bfdh_pkg::ST_CHECK: begin
            if (!ram_rdata[0] || last_probe) begin
               state_in = bfdh_pkg::ST_RESPOND;
            end else begin
               state_in = bfdh_pkg::ST_START;
            end
         end
         bfdh_pkg::ST_RESPOND: begin
            if (rsp_free) begin
               state_in = bfdh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfdh_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = probe_addr;
      ram_wdata = 1'b1;
      mod_start = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_ff;
            ram_wdata = 1'b0;
         end
         bfdh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         bfdh_pkg::ST_START: begin
            mod_start = 1'b1;
         end
         bfdh_pkg::ST_PROBE: begin
            ram_en = 1'b1;
            ram_we = (op_ff == bfdh_pkg::OP_INSERT);
         end
         default: begin
            ram_en = 1'b0;
         end
      endcase
   end

   // datapath and configuration
   always_comb begin
      num_bits_in    = num_bits_ff;
      hash_count_in  = hash_count_ff;
      op_in          = op_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      modulus_in     = modulus_ff;
      probes_in      = probes_ff;
      probe_idx_in   = probe_idx_ff;
      present_in     = present_ff;
      clr_addr_in    = clr_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_present_in = rsp_present_ff;

      if (csr_wr_en) begin
         case (csr_index)
            bfdh_pkg::CSR_NUM_BITS:   num_bits_in   = csr_wr_data[NB-1:0];
            bfdh_pkg::CSR_HASH_COUNT: hash_count_in = csr_wr_data[HC-1:0];
            default: begin
               num_bits_in = num_bits_ff;
            end
         endcase
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         bfdh_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_operation;
               acc_in       = req_key_hash;
               step_in      = (req_step_hash == '0) ? bfdh_pkg::ZERO_STEP_SUBST
                                                    : req_step_hash;
               modulus_in   = eff_modulus;
               probes_in    = eff_probes;
               probe_idx_in = '0;
               present_in   = 1'b1;
            end
         end
         bfdh_pkg::ST_PROBE: begin
            if (op_ff == bfdh_pkg::OP_INSERT) begin
               acc_in       = acc_ff + step_ff;
               probe_idx_in = probe_idx_next;
            end
         end
         bfdh_pkg::ST_CHECK: begin
            if (ram_rdata[0]) begin
               acc_in       = acc_ff + step_ff;
               probe_idx_in = probe_idx_next;
            end else begin
               present_in = 1'b0;
            end
         end
         bfdh_pkg::ST_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = present_ff;
            end
         end
         default: begin
            present_in = present_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfdh_pkg::ST_CLEAR;
         num_bits_ff   <= bfdh_pkg::NUM_BITS_RESET;
         hash_count_ff <= bfdh_pkg::HASH_COUNT_RESET;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_bits_ff   <= num_bits_in;
         hash_count_ff <= hash_count_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      modulus_ff     <= modulus_in;
      probes_ff      <= probes_in;
      probe_idx_ff   <= probe_idx_in;
      present_ff     <= present_in;
      rsp_present_ff <= rsp_present_in;
   end

   bfdh_mod_unit u_mod_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (acc_ff),
      .modulus  (modulus_ff),
      .result   (mod_result)
   );

   bfdh_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_bit_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_possibly_present = rsp_present_ff;

endmodule

// ----- hw/rtl/bfdh_checker.sv -----
// ----------------------------------------------------------------------------
// Bloom filter port checker
// Port-level properties of the bloom filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bloom_filter_double_hash_macros.svh"

module bfdh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_possibly_present
);

   // an accepted word takes req_ready low in the next cycle
   `BFDH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "req_ready high right after an accept")

   // a new result is written back only as the sequencer returns to idle
   `BFDH_ASSERT_NOW(a_result_frees_input, clock, reset, $rose(rsp_valid), req_ready, "result appeared while the input side stayed busy")

   // hold a stalled result
   `BFDH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_possibly_present), "stalled result dropped or changed")

endmodule

bind bloom_filter_double_hash bfdh_checker u_checker (.*);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Bloom filter double-hash testbench
// Drives insert and query words through the bloom filter, keeps its own
// copy of the bit store and the two registers, and predicts the presence
// flag of each accepted word. Runs a directed pass over the corner cases,
// then randomized phases under different register settings, sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HW = bfdh_pkg::HASH_W;
   localparam int DW = bfdh_pkg::CSR_DATA_W;
   localparam int IW = bfdh_pkg::CSR_INDEX_W;

   localparam int unsigned CYCLE_LIMIT  = 6000000;
   localparam int unsigned HOLD_CYCLES  = 3000;
   localparam int unsigned DRAIN_CYCLES = 1100;
   localparam int unsigned PHASE_WORDS  = 154;
   localparam int unsigned POOL_DEPTH   = 48;

   // indexes with no register behind them
   localparam logic [IW-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [IW-1:0] CSR_SPARE_HI = 2'd3;

   class bloom_scoreboard;
      bit                                filter_bits [bfdh_pkg::MAX_BITS_DEFAULT];
      logic [bfdh_pkg::NUM_BITS_W-1:0]   num_bits;
      logic [bfdh_pkg::HASH_COUNT_W-1:0] hash_count;
      bit                                presence_due [$];
      int unsigned                       error_count;

      function new();
         num_bits    = bfdh_pkg::NUM_BITS_RESET;
         hash_count  = bfdh_pkg::HASH_COUNT_RESET;
         error_count = 0;
      endfunction

      function void write_reg(logic [IW-1:0] index, logic [DW-1:0] data);
         if (index == bfdh_pkg::CSR_NUM_BITS) begin
            num_bits = data[bfdh_pkg::NUM_BITS_W-1:0];
         end else if (index == bfdh_pkg::CSR_HASH_COUNT) begin
            hash_count = data[bfdh_pkg::HASH_COUNT_W-1:0];
         end
      endfunction

      // walk the probe sequence; set bits on insert, test them on query
      function bit probe_filter(logic op, logic [HW-1:0] key, logic [HW-1:0] step);
         logic [HW-1:0] modulus;
         logic [HW-1:0] stride;
         logic [HW-1:0] pos;
         int unsigned   probes;
         bit            found;
         if (num_bits == 0) begin
            modulus = HW'(1);
         end else if (32'(num_bits) > bfdh_pkg::MAX_BITS_DEFAULT) begin
            modulus = HW'(bfdh_pkg::MAX_BITS_DEFAULT);
         end else begin
            modulus = HW'(num_bits);
         end
         probes = (32'(hash_count) > bfdh_pkg::MAX_HASHES_DEFAULT) ?
                  bfdh_pkg::MAX_HASHES_DEFAULT : 32'(hash_count);
         stride = (step == '0) ? bfdh_pkg::ZERO_STEP_SUBST : step;
         found  = 1'b1;
         for (int unsigned i = 0; i < probes && found; i++) begin
            pos = (key + HW'(i) * stride) % modulus;
            if (op == bfdh_pkg::OP_QUERY) begin
               if (!filter_bits[pos[15:0]]) found = 1'b0;
            end else begin
               filter_bits[pos[15:0]] = 1'b1;
            end
         end
         return found;
      endfunction

      function void note_request(logic op, logic [HW-1:0] key, logic [HW-1:0] step);
         presence_due.push_back(probe_filter(op, key, step));
      endfunction

      function void check_response(logic got);
         bit want;
         if (presence_due.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %0b", $time, got);
            error_count++;
         end else begin
            want = presence_due.pop_front();
            if (got !== want) begin
               $display("%0t: possibly_present mismatch, expected %0b, got %0b",
                        $time, want, got);
               error_count++;
            end
         end
      endfunction

      function int unsigned pending();
         return presence_due.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_operation;
   logic [HW-1:0]           req_key_hash;
   logic [HW-1:0]           req_step_hash;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_possibly_present;
   logic                    csr_wr_en;
   logic [IW-1:0]           csr_index;
   logic [DW-1:0]           csr_wr_data;

   bloom_scoreboard         sb;
   logic [2*HW-1:0]         key_pool [$];
   int unsigned             send_idle_pct;
   int unsigned             rsp_stall_pct;
   int unsigned             cycle_count = 0;
   bit                      hold_armed;
   logic                    rsp_hold;

   bloom_filter_double_hash u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_key_hash         (req_key_hash),
      .req_step_hash        (req_step_hash),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_possibly_present (rsp_possibly_present),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_possibly_present);
         if (req_valid && req_ready) sb.note_request(req_operation, req_key_hash, req_step_hash);
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off so the block fills and back-pressures its input
   initial begin
      rsp_hold = 1'b0;
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic send_key(input logic op, input logic [HW-1:0] key,
                           input logic [HW-1:0] step);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 300)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_hash  <= key;
      req_step_hash <= step;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_key();
      int unsigned     pick;
      logic            op;
      logic [HW-1:0]   key;
      logic [HW-1:0]   step;
      logic [2*HW-1:0] entry;
      pick = $urandom_range(99);
      key  = {$urandom, $urandom};
      step = ($urandom_range(19) == 0) ? '0 : {$urandom, $urandom};
      if (pick < 45 || key_pool.size() == 0) begin
         op = bfdh_pkg::OP_INSERT;
         key_pool.push_back({key, step});
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end else if (pick < 85) begin
         // query a key that went in earlier
         op    = bfdh_pkg::OP_QUERY;
         entry = key_pool[$urandom_range(key_pool.size() - 1)];
         key   = entry[2*HW-1:HW];
         step  = entry[HW-1:0];
      end else begin
         op = bfdh_pkg::OP_QUERY;
      end
      send_key(op, key, step);
   endtask

   // drop valid, let the last accept be noted, and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IW-1:0] index,
                            input logic [DW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      sb.write_reg(index, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned bit_tab [8];
      int unsigned probe_tab [8];
      bit_tab   = '{40, 65536, 1000, 64, 65536, 1, 257, 65535};
      probe_tab = '{1, 7, 3, 2, 16, 4, 5, 4};
      sb            = new();
      hold_armed    = 1'b0;
      send_idle_pct = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= bfdh_pkg::OP_INSERT;
      req_key_hash  <= '0;
      req_step_hash <= '0;
      rsp_stall_pct <= 0;
      csr_wr_en     <= 1'b0;
      csr_index     <= bfdh_pkg::CSR_NUM_BITS;
      csr_wr_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, zero step and all-ones wrap
      send_key(bfdh_pkg::OP_QUERY, '0, '0);
      send_key(bfdh_pkg::OP_INSERT, '0, '0);
      send_key(bfdh_pkg::OP_QUERY, '0, '0);
      send_key(bfdh_pkg::OP_QUERY, '0, bfdh_pkg::ZERO_STEP_SUBST);
      send_key(bfdh_pkg::OP_INSERT, '1, '1);
      send_key(bfdh_pkg::OP_QUERY, '1, '1);
      send_key(bfdh_pkg::OP_QUERY, 64'h8000_0000_0000_0000, 64'h1);

      settle();
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'd16);
      send_key(bfdh_pkg::OP_INSERT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      send_key(bfdh_pkg::OP_QUERY, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);

      // no probes at all
      settle();
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'd0);
      send_key(bfdh_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_key(bfdh_pkg::OP_QUERY, 64'h3c3c_3c3c_3c3c_3c3c, 64'hc3c3_c3c3_c3c3_c3c3);

      // both registers past their limits
      settle();
      write_csr(bfdh_pkg::CSR_NUM_BITS, 17'h1ffff);
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'h1f);
      send_key(bfdh_pkg::OP_INSERT, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001);
      send_key(bfdh_pkg::OP_QUERY, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001);
      send_key(bfdh_pkg::OP_QUERY, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000);

      // zero size folds every probe onto bit 0
      settle();
      write_csr(bfdh_pkg::CSR_NUM_BITS, 17'd0);
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'd1);
      send_key(bfdh_pkg::OP_QUERY, 64'd5, 64'd9);
      send_key(bfdh_pkg::OP_INSERT, 64'd5, 64'd9);
      send_key(bfdh_pkg::OP_QUERY, 64'd6, 64'd0);

      settle();
      write_csr(bfdh_pkg::CSR_NUM_BITS, 17'd1);
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'd2);
      send_key(bfdh_pkg::OP_QUERY, '1, 64'd3);

      settle();
      write_csr(CSR_SPARE_LO, 17'd3);
      write_csr(CSR_SPARE_HI, 17'h1ffff);
      send_key(bfdh_pkg::OP_QUERY, 64'h1234_0000_0000_4321, 64'd2);

      settle();
      write_csr(bfdh_pkg::CSR_NUM_BITS, 17'd8);
      write_csr(bfdh_pkg::CSR_HASH_COUNT, 17'd3);
      send_key(bfdh_pkg::OP_QUERY, '1, '1);
      send_key(bfdh_pkg::OP_INSERT, 64'hffff_ffff_ffff_fffe, 64'h1);
      send_key(bfdh_pkg::OP_QUERY, 64'hffff_ffff_ffff_fffe, 64'h1);

      for (int phase = 0; phase < 8; phase++) begin
         settle();
         if (phase == 5) begin
            write_csr(bfdh_pkg::CSR_NUM_BITS, DW'($urandom_range(1, 65536)));
            write_csr(bfdh_pkg::CSR_HASH_COUNT, DW'($urandom_range(1, 8)));
         end else begin
            write_csr(bfdh_pkg::CSR_NUM_BITS, DW'(bit_tab[phase]));
            write_csr(bfdh_pkg::CSR_HASH_COUNT, DW'(probe_tab[phase]));
         end
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 69;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 69;
            end
            default: begin
               send_idle_pct = 16;
               rsp_stall_pct <= 16;
            end
         endcase
         if (phase == 0) hold_armed = 1'b1;
         repeat (PHASE_WORDS) send_random_key();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
